[design/b3c_pkg.sv]
// Shared types, constants and helper functions for the 3D box corner generator.
`timescale 1ns / 1ps
package b3c_pkg;

  // Fixed-point one in the unsigned Q.29 format of the polynomial evaluation.
  localparam logic [29:0] FIX_ONE = 30'h2000_0000;

  // Half turn and quarter turn of yaw in Q2.13 radians.
  localparam logic signed [16:0] YAW_PI      = 17'sd25736;
  localparam logic signed [16:0] YAW_HALF_PI = 17'sd12868;

  // Horner divisors of the sine and cosine series, first step first.
  localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [4] = '{90, 56, 30, 12};

  // Default depth of the box queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register byte addresses.
  localparam logic [2:0] ADDR_MIN_SCORE = 3'd0;

  // One box after the front has worked out its rotation products.
  typedef struct packed {
    logic [7:0]         cls;
    logic [7:0]         attr;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cy;
    logic [30:0]        dy;
    logic signed [46:0] pxc;   // size_x * cos
    logic signed [46:0] pzs;   // size_z * sin
    logic signed [46:0] pxs;   // size_x * sin
    logic signed [46:0] pzc;   // size_z * cos
  } box_t;

  // Clamp a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[design/b3c_horner_step.sv]
// One Horner step t_out = ONE - ((x2 * t_in) >> 29) / DIVISOR, three register stages.
`timescale 1ns / 1ps
module b3c_horner_step #(
  parameter int unsigned DIVISOR = 6
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] x2_in,
  input  logic [29:0] t_in,
  output logic [30:0] x2_out,
  output logic [29:0] t_out
);

  // Truncated reciprocal; the quotient it gives is low by at most one.
  localparam logic [29:0] RECIP = 30'((64'd1 << 32) / DIVISOR);
  localparam logic [31:0] DIV32 = 32'(DIVISOR);

  logic [60:0] prod;
  logic [30:0] y_a;
  logic [30:0] x2_a;
  logic [60:0] mq;
  logic [28:0] q0_b;
  logic [30:0] y_b;
  logic [30:0] x2_b;
  logic [31:0] rem;
  logic [29:0] quo;
  logic [29:0] t_c;
  logic [30:0] x2_c;

  assign prod = 61'(x2_in) * 61'(t_in);
  assign mq   = 61'(y_a) * 61'(RECIP);
  assign rem  = 32'(y_b) - 32'(q0_b) * DIV32;
  assign quo  = 30'(q0_b) + ((rem >= DIV32) ? 30'd1 : 30'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      y_a  <= prod[59:29];
      x2_a <= x2_in;
      q0_b <= mq[60:32];
      y_b  <= y_a;
      x2_b <= x2_a;
      t_c  <= b3c_pkg::FIX_ONE - quo;
      x2_c <= x2_b;
    end
  end

  assign t_out  = t_c;
  assign x2_out = x2_c;

endmodule

[design/b3c_front.sv]
// Front part: accepts boxes, drops low scores, evaluates sine and cosine, forms products.
`timescale 1ns / 1ps
module b3c_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         min_score,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          class_num,
  input  logic [7:0]          attribute_id,
  input  logic [15:0]         score,
  input  logic signed [31:0]  bottom_x,
  input  logic signed [31:0]  bottom_y,
  input  logic signed [31:0]  bottom_z,
  input  logic [30:0]         size_x,
  input  logic [30:0]         size_y,
  input  logic [30:0]         size_z,
  input  logic signed [15:0]  yaw,
  output logic                box_valid,
  input  logic                box_ready,
  output b3c_pkg::box_t       box
);

  // Stage 0 holds the reduced angle, stage 1 the square, each Horner step adds three,
  // then rounding, signs, and the product register.
  localparam int SB_LAST = 15;
  localparam int V_LAST  = 16;

  typedef struct packed {
    logic [7:0]         cls;
    logic [7:0]         attr;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic [30:0]        dx;
    logic [30:0]        dy;
    logic [30:0]        dz;
    logic [13:0]        mag;
    logic               flip;
    logic               sneg;
  } side_t;

  function automatic logic [14:0] to_q15(input logic [30:0] v);
    logic [31:0] r;
    r = 32'(v) + 32'd8192;
    if (|r[31:29]) begin
      return 15'h7FFF;
    end
    return r[28:14];
  endfunction

  side_t              sb [0:SB_LAST];
  logic [V_LAST:0]    vld;
  logic               adv;
  logic               keep;
  side_t              in_side;
  logic signed [16:0] yaw_ext;
  logic signed [16:0] ang;
  logic signed [16:0] ang_abs;
  logic               ang_flip;
  logic [27:0]        mag_sq;
  logic [30:0]        x2;
  logic [30:0]        sx2 [0:4];
  logic [29:0]        st  [0:4];
  logic [29:0]        ct  [0:4];
  logic [43:0]        sin_prod;
  logic [60:0]        cos_prod;
  logic [30:0]        sv_raw;
  logic [30:0]        cos_p;
  logic [30:0]        cos_v;
  logic signed [15:0] s_val;
  logic signed [15:0] c_val;
  logic signed [31:0] dxs;
  logic signed [31:0] dzs;
  b3c_pkg::box_t      box_reg;

  assign adv      = !vld[V_LAST] || box_ready;
  assign in_ready = adv;
  assign keep     = score >= min_score;

  // Bring yaw into one half turn; a step of pi flips both sine and cosine.
  always_comb begin
    yaw_ext  = 17'(yaw);
    ang      = yaw_ext;
    ang_flip = 1'b0;
    if (yaw_ext > b3c_pkg::YAW_HALF_PI) begin
      ang      = yaw_ext - b3c_pkg::YAW_PI;
      ang_flip = 1'b1;
    end else if (yaw_ext < -b3c_pkg::YAW_HALF_PI) begin
      ang      = yaw_ext + b3c_pkg::YAW_PI;
      ang_flip = 1'b1;
    end
    ang_abs      = ang[16] ? -ang : ang;
    in_side.cls  = class_num;
    in_side.attr = attribute_id;
    in_side.bx   = bottom_x;
    in_side.by   = bottom_y;
    in_side.bz   = bottom_z;
    in_side.dx   = size_x;
    in_side.dy   = size_y;
    in_side.dz   = size_z;
    in_side.mag  = ang_abs[13:0];
    in_side.flip = ang_flip;
    in_side.sneg = ang[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[V_LAST-1:0], in_valid && keep};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= in_side;
      for (int i = 1; i <= SB_LAST; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // With m = mag << 16, (m * m) >> 29 is exactly mag * mag << 3.
  assign mag_sq = sb[0].mag * sb[0].mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2 <= {mag_sq, 3'b000};
    end
  end

  assign sx2[0] = x2;
  assign st[0]  = b3c_pkg::FIX_ONE;
  assign ct[0]  = b3c_pkg::FIX_ONE;

  for (genvar g = 0; g < 4; g++) begin : g_step
    b3c_horner_step #(.DIVISOR(b3c_pkg::SIN_DIV[g])) u_sin (
      .clk    (clk),
      .en     (adv),
      .x2_in  (sx2[g]),
      .t_in   (st[g]),
      .x2_out (sx2[g+1]),
      .t_out  (st[g+1])
    );
    b3c_horner_step #(.DIVISOR(b3c_pkg::COS_DIV[g])) u_cos (
      .clk    (clk),
      .en     (adv),
      .x2_in  (sx2[g]),
      .t_in   (ct[g]),
      .x2_out (),
      .t_out  (ct[g+1])
    );
  end

  // Sine magnitude is (m * t) >> 29, that is mag * t >> 13; cosine takes half a last product.
  assign sin_prod = 44'(sb[13].mag) * 44'(st[4]);
  assign cos_prod = 61'(sx2[4]) * 61'(ct[4]);
  assign cos_v    = (cos_p >= 31'(b3c_pkg::FIX_ONE)) ? 31'd0 : 31'(b3c_pkg::FIX_ONE) - cos_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_raw <= sin_prod[43:13];
      cos_p  <= cos_prod[60:30];
      s_val  <= (sb[14].sneg != sb[14].flip) ? -$signed({1'b0, to_q15(sv_raw)})
                                             : $signed({1'b0, to_q15(sv_raw)});
      c_val  <= sb[14].flip ? -$signed({1'b0, to_q15(cos_v)})
                            : $signed({1'b0, to_q15(cos_v)});
    end
  end

  assign dxs = $signed({1'b0, sb[15].dx});
  assign dzs = $signed({1'b0, sb[15].dz});

  always_ff @(posedge clk) begin
    if (adv) begin
      box_reg.cls  <= sb[15].cls;
      box_reg.attr <= sb[15].attr;
      box_reg.bx   <= sb[15].bx;
      box_reg.by   <= sb[15].by;
      box_reg.bz   <= sb[15].bz;
      box_reg.dy   <= sb[15].dy;
      box_reg.cy   <= b3c_pkg::sat32(34'(sb[15].by) - $signed({4'b0000, sb[15].dy[30:1]}));
      box_reg.pxc  <= 47'(dxs) * 47'(c_val);
      box_reg.pzs  <= 47'(dzs) * 47'(s_val);
      box_reg.pxs  <= 47'(dxs) * 47'(s_val);
      box_reg.pzc  <= 47'(dzs) * 47'(c_val);
    end
  end

  assign box_valid = vld[V_LAST];
  assign box       = box_reg;

  a_keep_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (score >= min_score) |=> vld[0])
    else $error("accepted box above threshold did not enter the pipeline");

endmodule

[design/b3c_queue.sv]
// Short first-in first-out queue of boxes between the front and the back.
`timescale 1ns / 1ps
module b3c_queue #(
  parameter int unsigned DEPTH = b3c_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  b3c_pkg::box_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output b3c_pkg::box_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  b3c_pkg::box_t mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue holds more items than its depth");

endmodule

[design/b3c_back.sv]
// Back part: walks the eight corners of the head box and drives the result register.
`timescale 1ns / 1ps
module b3c_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                box_valid,
  output logic                box_ready,
  input  b3c_pkg::box_t       box,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          corner_index,
  output logic signed [31:0]  corner_x,
  output logic signed [31:0]  corner_y,
  output logic signed [31:0]  corner_z,
  output logic signed [31:0]  centre_x,
  output logic signed [31:0]  centre_y,
  output logic signed [31:0]  centre_z,
  output logic [7:0]          out_class,
  output logic [7:0]          out_attribute,
  output logic                last_corner
);

  // Unit pattern per corner as {nx, ny, nz}.
  localparam logic [2:0] PATTERN [8] = '{3'b000, 3'b001, 3'b011, 3'b010,
                                         3'b100, 3'b101, 3'b111, 3'b110};
  localparam logic [2:0] CORNER_LAST = 3'd7;
  localparam logic signed [48:0] HALF = 49'sd32768;

  logic               adv;
  logic               fire;
  logic [2:0]         k;
  logic [2:0]         pat;
  logic signed [48:0] ex;
  logic signed [48:0] ez;
  logic               s1_valid;
  logic [2:0]         s1_k;
  logic signed [32:0] s1_ox;
  logic signed [32:0] s1_oz;
  logic signed [31:0] s1_oy;
  b3c_pkg::box_t      s1_box;

  assign adv       = !out_valid || out_ready;
  assign fire      = box_valid && adv;
  assign box_ready = fire && (k == CORNER_LAST);
  assign pat       = PATTERN[k];

  // Offsets before rounding: signs of x and z come from the pattern, plus one half.
  always_comb begin
    ex = (pat[2] ? 49'(box.pxc) : -49'(box.pxc))
       + (pat[0] ? 49'(box.pzs) : -49'(box.pzs)) + HALF;
    ez = (pat[2] ? -49'(box.pxs) : 49'(box.pxs))
       + (pat[0] ? 49'(box.pzc) : -49'(box.pzc)) + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= box_valid;
      out_valid <= s1_valid;
      if (box_valid) begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k   <= k;
      s1_ox  <= ex[48:16];
      s1_oz  <= ez[48:16];
      s1_oy  <= pat[1] ? 32'sd0 : -$signed({1'b0, box.dy});
      s1_box <= box;
      corner_index  <= s1_k;
      corner_x      <= b3c_pkg::sat32(34'(s1_box.bx) + 34'(s1_ox));
      corner_y      <= b3c_pkg::sat32(34'(s1_box.by) + 34'(s1_oy));
      corner_z      <= b3c_pkg::sat32(34'(s1_box.bz) + 34'(s1_oz));
      centre_x      <= s1_box.bx;
      centre_y      <= s1_box.cy;
      centre_z      <= s1_box.bz;
      out_class     <= s1_box.cls;
      out_attribute <= s1_box.attr;
      last_corner   <= s1_k == CORNER_LAST;
    end
  end

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_corner == (corner_index == CORNER_LAST)))
    else $error("last corner flag does not match corner index");

  a_counter_steps: assert property (@(posedge clk) disable iff (rst)
    fire && (k != CORNER_LAST) |=> k == $past(k) + 3'd1)
    else $error("corner counter skipped a corner");

endmodule

[design/box3d_corner_generator.sv]
// Top level of the 3D box corner generator: register port, front, queue and back.
`timescale 1ns / 1ps
// Each box item carries class, attribute, score, bottom centre, extents and yaw. A box
// whose score is below the minimum score register (APB byte address 0, reset 0) is
// accepted and dropped. Every other box gives eight result items, one per corner in the
// fixed pattern order, each with the box centre and the class and attribute copied over;
// last_corner marks the eighth. The front is a fully pipelined 17-stage path (sine and
// cosine by two Horner chains of four steps, each step one multiply and one reciprocal
// division over three stages, then rounding and the four size-by-angle products) that
// takes one box per cycle unless a full queue holds its last stage. A short queue holds
// finished boxes, and the back emits one corner per cycle through a two-stage path while
// a box waits and out_ready does not hold it, so a passing box gives eight results and a
// dropped box still takes a slot in the front but gives none.
// Corner coordinates and centre_y saturate to the signed 32-bit range.
module box3d_corner_generator #(
  parameter int unsigned QUEUE_DEPTH = b3c_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Box input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         class_num,
  input  logic [7:0]         attribute_id,
  input  logic [15:0]        score,
  input  logic signed [31:0] bottom_x,
  input  logic signed [31:0] bottom_y,
  input  logic signed [31:0] bottom_z,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic signed [15:0] yaw,
  // Corner result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         corner_index,
  output logic signed [31:0] corner_x,
  output logic signed [31:0] corner_y,
  output logic signed [31:0] corner_z,
  output logic signed [31:0] centre_x,
  output logic signed [31:0] centre_y,
  output logic signed [31:0] centre_z,
  output logic [7:0]         out_class,
  output logic [7:0]         out_attribute,
  output logic               last_corner
);

  logic [15:0]   min_score;
  logic          reg_hit;
  logic          f_valid;
  logic          f_ready;
  b3c_pkg::box_t f_box;
  logic          q_valid;
  logic          q_ready;
  b3c_pkg::box_t q_box;

  // The register decode ignores the two byte-offset bits.
  assign reg_hit = paddr[2] == b3c_pkg::ADDR_MIN_SCORE[2];
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'h0000, min_score} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_score <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      min_score <= pwdata[15:0];
    end
  end

  b3c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .min_score    (min_score),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .class_num    (class_num),
    .attribute_id (attribute_id),
    .score        (score),
    .bottom_x     (bottom_x),
    .bottom_y     (bottom_y),
    .bottom_z     (bottom_z),
    .size_x       (size_x),
    .size_y       (size_y),
    .size_z       (size_z),
    .yaw          (yaw),
    .box_valid    (f_valid),
    .box_ready    (f_ready),
    .box          (f_box)
  );

  b3c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_box),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_box)
  );

  b3c_back u_back (
    .clk           (clk),
    .rst           (rst),
    .box_valid     (q_valid),
    .box_ready     (q_ready),
    .box           (q_box),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .corner_index  (corner_index),
    .corner_x      (corner_x),
    .corner_y      (corner_y),
    .corner_z      (corner_z),
    .centre_x      (centre_x),
    .centre_y      (centre_y),
    .centre_z      (centre_z),
    .out_class     (out_class),
    .out_attribute (out_attribute),
    .last_corner   (last_corner)
  );

endmodule
